FILE: sv/stf_pkg.sv
// stf_pkg: shared types, line codes and crc helper for the slip transmit framer
// no dependencies; used by stf_front, stf_queue, stf_back and slip_tx_framer_crc8
`default_nettype none

package stf_pkg;

  localparam logic [7:0] FRAME_END     = 8'hC0;
  localparam logic [7:0] FRAME_ESC     = 8'hDB;
  localparam logic [7:0] FRAME_ESC_END = 8'hDC;
  localparam logic [7:0] FRAME_ESC_ESC = 8'hDD;
  localparam logic [7:0] CRC_POLY      = 8'h8C;

  // one classified item as handed from the front to the back
  typedef struct packed {
    logic       has_data;
    logic [7:0] data;
    logic       has_crc;
    logic [7:0] crc;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_DATA,
    PH_DATA_ESC,
    PH_CRC,
    PH_CRC_ESC,
    PH_END
  } phase_e;

  // reflected crc-8, one byte, eight shift steps
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FRAME_END) || (b == FRAME_ESC);
  endfunction

  // second byte of an escape pair
  function automatic logic [7:0] esc_code(input logic [7:0] b);
    return (b == FRAME_END) ? FRAME_ESC_END : FRAME_ESC_ESC;
  endfunction

  // first byte sent for a payload or crc byte
  function automatic logic [7:0] esc_lead(input logic [7:0] b);
    return needs_esc(b) ? FRAME_ESC : b;
  endfunction

endpackage

`default_nettype wire

FILE: sv/slip_tx_framer_crc8.sv
// slip_tx_framer_crc8: top level of the slip transmit framer with optional crc-8 trailer
// depends on stf_pkg, stf_front, stf_queue and stf_back
`default_nettype none

// Payload bytes enter through a queue-style push port and leave as SLIP line bytes
// through a queue-style pop port. The front takes one item per cycle while the
// command queue (QUEUE_DEPTH entries) has room, updates the crc-8 and drops items that
// carry neither a byte nor a frame end. The back sends one line byte per cycle while
// pop keeps up: a plain payload byte gives one line byte, an escaped one two, and a
// closing item adds one or two bytes for the crc byte (when enabled) and one for the
// end marker, so an item gives one to five bytes. run_last marks the last byte of each
// item. crc_enable is sampled at accept time; write it only while the block is idle.
module slip_tx_framer_crc8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       has_byte_i,
  input  wire logic       frame_last_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      line_byte_o,
  output logic            run_last_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i
);

  logic          q_push, q_pop, q_full, q_empty;
  stf_pkg::cmd_t q_in, q_out;

  stf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .has_byte_i   (has_byte_i),
    .frame_last_i (frame_last_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_in)
  );

  stf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty)
  );

  stf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_out),
    .q_pop_o     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .line_byte_o (line_byte_o),
    .run_last_o  (run_last_o)
  );

  // an escape lead byte is always followed by its code byte
  a_esc_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && line_byte_o == stf_pkg::FRAME_ESC) |-> !run_last_o)
    else $error("escape byte marked as last of its item");

  // a raw end marker only ever closes an item
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && line_byte_o == stf_pkg::FRAME_END) |-> run_last_o)
    else $error("end marker not marked as last of its item");

  // the back only retires a command that is present
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command queue popped while empty");

endmodule

`default_nettype wire

FILE: sv/stf_front.sv
// stf_front: accepts input items, runs the crc and classifies each item into a command
// depends on stf_pkg
`default_nettype none

module stf_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          has_byte_i,
  input  wire logic          frame_last_i,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_data_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output stf_pkg::cmd_t      q_cmd_o
);

  logic       crc_en_q, crc_en_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] crc_next;
  logic       accept;
  logic       upd;

  assign full        = q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = push && !q_full_i;
  assign upd         = has_byte_i && crc_en_q;
  assign crc_next    = stf_pkg::crc8_update(crc_q, data_byte_i);

  always_comb begin
    crc_en_d = crc_en_q;
    if (cfg_valid_i && cfg_ready_o) begin
      crc_en_d = cfg_data_i;
    end
  end

  always_comb begin
    crc_d = crc_q;
    if (accept) begin
      if (frame_last_i) begin
        crc_d = 8'h00;
      end else if (upd) begin
        crc_d = crc_next;
      end
    end
  end

  // idle items give no line bytes and are dropped here
  assign q_push_o = accept && (has_byte_i || frame_last_i);

  always_comb begin
    q_cmd_o.has_data = has_byte_i;
    q_cmd_o.data     = data_byte_i;
    q_cmd_o.has_crc  = frame_last_i && crc_en_q;
    q_cmd_o.crc      = upd ? crc_next : crc_q;
    q_cmd_o.last     = frame_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_en_q <= 1'b0;
      crc_q    <= 8'h00;
    end else begin
      crc_en_q <= crc_en_d;
      crc_q    <= crc_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/stf_queue.sv
// stf_queue: short command queue between the front and the back
// depends on stf_pkg
`default_nettype none

module stf_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire stf_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output stf_pkg::cmd_t      pop_data_o,
  output logic               empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  stf_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/stf_back.sv
// stf_back: expands each queued command into slip line bytes, one per cycle while pop keeps up
// depends on stf_pkg; holds the output register that drives the result side
`default_nettype none

module stf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire stf_pkg::cmd_t q_cmd_i,
  output logic               q_pop_o,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         line_byte_o,
  output logic               run_last_o
);

  stf_pkg::phase_e phase_q, phase_d, first_ph, cur_ph, next_ph;
  logic            busy_q, busy_d;
  logic            fin;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q, byte_c;
  logic            last_q;
  logic            can_load, fire;

  assign can_load = !out_valid_q || pop;
  assign fire     = !q_empty_i && can_load;

  always_comb begin
    if (q_cmd_i.has_data) begin
      first_ph = stf_pkg::PH_DATA;
    end else if (q_cmd_i.has_crc) begin
      first_ph = stf_pkg::PH_CRC;
    end else begin
      first_ph = stf_pkg::PH_END;
    end
  end

  assign cur_ph = busy_q ? phase_q : first_ph;

  // next phase, and whether this byte closes the command
  always_comb begin
    next_ph = stf_pkg::PH_END;
    fin     = 1'b0;
    unique case (cur_ph)
      stf_pkg::PH_DATA: begin
        if (stf_pkg::needs_esc(q_cmd_i.data)) begin
          next_ph = stf_pkg::PH_DATA_ESC;
        end else if (q_cmd_i.has_crc) begin
          next_ph = stf_pkg::PH_CRC;
        end else if (q_cmd_i.last) begin
          next_ph = stf_pkg::PH_END;
        end else begin
          fin = 1'b1;
        end
      end
      stf_pkg::PH_DATA_ESC: begin
        if (q_cmd_i.has_crc) begin
          next_ph = stf_pkg::PH_CRC;
        end else if (q_cmd_i.last) begin
          next_ph = stf_pkg::PH_END;
        end else begin
          fin = 1'b1;
        end
      end
      stf_pkg::PH_CRC: begin
        next_ph = stf_pkg::needs_esc(q_cmd_i.crc) ? stf_pkg::PH_CRC_ESC : stf_pkg::PH_END;
      end
      stf_pkg::PH_CRC_ESC: begin
        next_ph = stf_pkg::PH_END;
      end
      stf_pkg::PH_END: begin
        fin = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  // byte for the current phase
  always_comb begin
    unique case (cur_ph)
      stf_pkg::PH_DATA:     byte_c = stf_pkg::esc_lead(q_cmd_i.data);
      stf_pkg::PH_DATA_ESC: byte_c = stf_pkg::esc_code(q_cmd_i.data);
      stf_pkg::PH_CRC:      byte_c = stf_pkg::esc_lead(q_cmd_i.crc);
      stf_pkg::PH_CRC_ESC:  byte_c = stf_pkg::esc_code(q_cmd_i.crc);
      stf_pkg::PH_END:      byte_c = stf_pkg::FRAME_END;
      default:              byte_c = stf_pkg::FRAME_END;
    endcase
  end

  assign q_pop_o     = fire && fin;
  assign busy_d      = fire ? !fin : busy_q;
  assign phase_d     = fire ? next_ph : phase_q;
  assign out_valid_d = fire || (out_valid_q && !pop);

  assign empty       = !out_valid_q;
  assign line_byte_o = byte_q;
  assign run_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= stf_pkg::PH_DATA;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_c;
      last_q <= fin;
    end
  end

endmodule

`default_nettype wire

FILE: dv/stf_line_checker.sv
`timescale 1ns / 1ps
// stf_line_checker: watches the push, pop and config channels of the slip framer,
// works out the encoded line bytes of every accepted item and compares them in order
// depends on stf_pkg
module stf_line_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       frame_last_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [7:0] line_byte_i,
  input  logic       run_last_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic       cfg_data_i,
  output int         pending_o,
  output int         fail_count_o,
  output int         checked_o
);

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } line_t;

  line_t      line_q[$];
  line_t      head;
  logic       crc_on;
  logic [7:0] crc_acc;
  logic [7:0] seq [0:4];
  int         seq_n;
  int         fails = 0;
  int         checked = 0;

  // reflected crc-8, lsb first
  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[0] ? ((r >> 1) ^ stf_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic stage(input logic [7:0] b);
    if (b == stf_pkg::FRAME_END || b == stf_pkg::FRAME_ESC) begin
      seq[seq_n]     = stf_pkg::FRAME_ESC;
      seq[seq_n + 1] = (b == stf_pkg::FRAME_END) ? stf_pkg::FRAME_ESC_END
                                                  : stf_pkg::FRAME_ESC_ESC;
      seq_n += 2;
    end else begin
      seq[seq_n] = b;
      seq_n += 1;
    end
  endtask

  task automatic predict_line(input logic [7:0] d, input logic h, input logic l);
    seq_n = 0;
    if (h) begin
      if (crc_on) crc_acc = crc_fold(crc_acc, d);
      stage(d);
    end
    if (l) begin
      if (crc_on) stage(crc_acc);
      seq[seq_n] = stf_pkg::FRAME_END;
      seq_n += 1;
      crc_acc = 8'h00;
    end
    for (int i = 0; i < seq_n; i++) begin
      head.code = seq[i];
      head.fin  = (i == seq_n - 1);
      line_q.push_back(head);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q.delete();
      crc_on  = 1'b0;
      crc_acc = 8'h00;
      pending_o    <= 0;
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        checked++;
        if (line_q.size() == 0) begin
          $display("%0t: line byte %02h (run_last %0b) with nothing expected",
                   $time, line_byte_i, run_last_i);
          fails++;
        end else begin
          head = line_q.pop_front();
          if (line_byte_i !== head.code) begin
            $display("%0t: line_byte expected %02h actual %02h",
                     $time, head.code, line_byte_i);
            fails++;
          end
          if (run_last_i !== head.fin) begin
            $display("%0t: run_last expected %0b actual %0b (line_byte %02h)",
                     $time, head.fin, run_last_i, line_byte_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) crc_on = cfg_data_i;
      if (push_i && !full_i) predict_line(data_byte_i, has_byte_i, frame_last_i);
      pending_o    <= line_q.size();
      fail_count_o <= fails;
      checked_o    <= checked;
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// tb: drives slip frames and crc settings into slip_tx_framer_crc8 and gives the verdict
// depends on stf_pkg, slip_tx_framer_crc8 and stf_line_checker
module tb;

  localparam int DRAIN_PAUSE   = 40;
  localparam int STALL_LIMIT   = 600;
  localparam int PHASE_ITEMS   = 20;
  localparam int RANDOM_PHASES = 6;
  // single-byte frames whose crc-8 comes out as an end marker or an escape
  localparam logic [7:0] CRC_GIVES_END = 8'h3A;
  localparam logic [7:0] CRC_GIVES_ESC = 8'h50;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       frame_last;
  logic       empty;
  logic       pop;
  logic [7:0] line_byte;
  logic       run_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       calm;
  int         pop_hold;
  int         stall_cycles = 0;
  int         pending;
  int         fail_count;
  int         checked;
  int         items_sent = 0;
  int         frames_sent = 0;
  int         settings_used = 0;

  slip_tx_framer_crc8 u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte),
    .has_byte_i  (has_byte),
    .frame_last_i(frame_last),
    .empty       (empty),
    .pop         (pop),
    .line_byte_o (line_byte),
    .run_last_o  (run_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  stf_line_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .data_byte_i (data_byte),
    .has_byte_i  (has_byte),
    .frame_last_i(frame_last),
    .empty_i     (empty),
    .pop_i       (pop),
    .line_byte_i (line_byte),
    .run_last_i  (run_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .fail_count_o(fail_count),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // line side: pop high except for random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      pop      <= 1'b0;
      pop_hold <= $urandom_range(0, 7);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("watchdog: nothing moved for %0d cycles, %0d line bytes outstanding",
             STALL_LIMIT, pending);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(input logic [7:0] d, input logic h, input logic l);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    push       <= 1'b1;
    data_byte  <= d;
    has_byte   <= h;
    frame_last <= l;
    do @(posedge clk_i); while (full);
    if (h || l) items_sent++;
    if (l) frames_sent++;
  endtask

  // block idle: every expected byte out, then time for dropped items to clear
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic set_crc(input logic en);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return stf_pkg::FRAME_END;
      1:       return stf_pkg::FRAME_ESC;
      2:       return stf_pkg::FRAME_ESC_END;
      3:       return stf_pkg::FRAME_ESC_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly short frames, a few long ones, the odd stray idle item or unclosed frame
  task automatic send_frame();
    int   len;
    logic on_byte;
    logic open;
    len     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 5);
    on_byte = $urandom_range(0, 1);
    open    = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, !open && on_byte && (i == len - 1));
    end
    if (!open && (len == 0 || !on_byte)) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int start;
    rst_ni     <= 1'b0;
    push       <= 1'b0;
    data_byte  <= 8'h00;
    has_byte   <= 1'b0;
    frame_last <= 1'b0;
    pop        <= 1'b0;
    pop_hold   <= 0;
    cfg_valid  <= 1'b0;
    cfg_data   <= 1'b0;
    calm       <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain framing, crc off
    set_crc(1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(stf_pkg::FRAME_END, 1'b1, 1'b0);
    send_item(stf_pkg::FRAME_ESC, 1'b1, 1'b0);
    send_item(stf_pkg::FRAME_ESC_END, 1'b1, 1'b0);
    send_item(stf_pkg::FRAME_ESC_ESC, 1'b1, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(stf_pkg::FRAME_END, 1'b1, 1'b1);
    send_item(stf_pkg::FRAME_ESC, 1'b1, 1'b1);

    // crc trailer, including crc values that need escaping
    set_crc(1'b1);
    send_item(CRC_GIVES_END, 1'b1, 1'b1);
    send_item(CRC_GIVES_ESC, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(stf_pkg::FRAME_END, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h7E, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // enable flipped inside an open frame
    send_item(8'h12, 1'b1, 1'b0);
    set_crc(1'b0);
    send_item(8'h34, 1'b1, 1'b0);
    set_crc(1'b1);
    send_item(stf_pkg::FRAME_ESC, 1'b1, 1'b1);
    // frame closed with crc off must still clear the accumulator
    send_item(stf_pkg::FRAME_END, 1'b1, 1'b0);
    set_crc(1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    set_crc(1'b1);
    send_item(8'h00, 1'b0, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_crc((p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      if (p == RANDOM_PHASES - 1) calm <= 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_frame();
    end

    settle();
    $display("ran %0d items in %0d closed frames across %0d crc enable writes",
             items_sent, frames_sent, settings_used);
    $display("compared %0d line bytes, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
